[rtl/euler_to_direction_cosine_matrix_assert.svh]
// Assertion macros for the attitude matrix block.
`ifndef EULER_TO_DIRECTION_COSINE_MATRIX_ASSERT_SVH
`define EULER_TO_DIRECTION_COSINE_MATRIX_ASSERT_SVH
`ifndef SYNTHESIS
`define E2D_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define E2D_ASSERT_RANGE(label, clk, rst_n, en, val, lim, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (en) |-> ((val) <= (lim) && (val) >= -(lim))) else $error(msg);
`else
`define E2D_ASSERT(label, clk, rst_n, prop, msg)
`define E2D_ASSERT_RANGE(label, clk, rst_n, en, val, lim, msg)
`endif
`endif

[rtl/e2d_pkg.sv]
// ----------------------------------------------------------------------------
// e2d_pkg
// Types, constants and the arctangent table of the attitude matrix block.
// ----------------------------------------------------------------------------
package e2d_pkg;

  localparam int AngleBitsDef    = 16;
  localparam int CordicStagesDef = 16;
  localparam int AtanEntries     = 24;
  localparam int CordW           = 34;
  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032875;
  localparam logic signed [15:0] Q14One = 16'sd16384;

  typedef struct packed {
    logic               op;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } e2d_in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } e2d_out_t;

  // One angle moving through the CORDIC row.
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
    logic [1:0]              q;
  } e2d_rot_t;

  function automatic logic signed [CordW-1:0] atan_phase(input int i);
    logic signed [CordW-1:0] t;
    begin
      case (i)
        0: t = 34'sd536870912;  1: t = 34'sd316933406;  2: t = 34'sd167458907;
        3: t = 34'sd85004756;   4: t = 34'sd42667331;   5: t = 34'sd21354465;
        6: t = 34'sd10680862;   7: t = 34'sd5340245;    8: t = 34'sd2670163;
        9: t = 34'sd1335087;    10: t = 34'sd667544;    11: t = 34'sd333772;
        12: t = 34'sd166886;    13: t = 34'sd83443;     14: t = 34'sd41721;
        15: t = 34'sd20860;     16: t = 34'sd10430;     17: t = 34'sd5215;
        18: t = 34'sd2607;      19: t = 34'sd1303;      20: t = 34'sd651;
        21: t = 34'sd325;       22: t = 34'sd162;       23: t = 34'sd81;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

  // Saturate a wide signed value to +/-1.0 in Q2.14.
  function automatic logic signed [15:0] sat_q14(input logic signed [47:0] v);
    logic signed [15:0] r;
    begin
      if (v > 48'sd16384) r = Q14One;
      else if (v < -48'sd16384) r = -Q14One;
      else r = v[15:0];
      return r;
    end
  endfunction

endpackage

[rtl/e2d_cordic_cell.sv]
// ----------------------------------------------------------------------------
// e2d_cordic_cell
// One registered CORDIC micro-rotation for the three angles of a beat.
// ----------------------------------------------------------------------------
module e2d_cordic_cell import e2d_pkg::*; #(
  parameter int Stage = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  e2d_rot_t    rot_i [3],
  input  logic [16:0] side_i,
  output e2d_rot_t    rot_o [3],
  output logic [16:0] side_o
);

  e2d_rot_t rot_d [3];
  e2d_rot_t rot_q [3];
  logic [16:0] side_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rot_d[a] = rot_i[a];
      if (rot_i[a].z >= 0) begin
        rot_d[a].x = rot_i[a].x - (rot_i[a].y >>> Stage);
        rot_d[a].y = rot_i[a].y + (rot_i[a].x >>> Stage);
        rot_d[a].z = rot_i[a].z - atan_phase(Stage);
      end else begin
        rot_d[a].x = rot_i[a].x + (rot_i[a].y >>> Stage);
        rot_d[a].y = rot_i[a].y - (rot_i[a].x >>> Stage);
        rot_d[a].z = rot_i[a].z + atan_phase(Stage);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q  <= rot_d;
      side_q <= side_i;
    end
  end

  assign rot_o  = rot_q;
  assign side_o = side_q;

endmodule

[rtl/e2d_matrix.sv]
// ----------------------------------------------------------------------------
// e2d_matrix
// Turns three sine/cosine pairs into the nine matrix entries, three stages.
// ----------------------------------------------------------------------------
module e2d_matrix import e2d_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               op_i,
  input  logic signed [15:0] sph_i, cph_i, sth_i, cth_i, sps_i, cps_i,
  output e2d_out_t           mat_o
);

  // Stage one: pair products in Q28.
  logic signed [31:0] p_ct_q, p_sc_q, p_cc_q, p_cs_q, p_ss_q, p_ct2_q, p_st_q,
                      p_cthsph_q, p_cthcph_q;
  logic signed [15:0] sph_q, cph_q, sth_q;
  logic               op1_q, op2_q;
  // Stage two: triple products in Q42 with the cross terms aligned.
  logic signed [47:0] t1_q, t2_q, u1_q, u2_q, u4_q, u5_q;
  logic signed [15:0] e0_q, e3_q, e6_q, e7_q, e8_q;
  e2d_out_t           mat_q;
  logic signed [15:0] m [9];

  function automatic logic signed [15:0] rnd2(input logic signed [31:0] p);
    logic signed [47:0] w;
    begin
      w = (48'(p) + 48'sd8192) >>> 14;
      return sat_q14(w);
    end
  endfunction

  function automatic logic signed [15:0] rnd3(input logic signed [47:0] s);
    logic signed [47:0] w;
    begin
      w = (s + 48'sd134217728) >>> 28;
      return sat_q14(w);
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ct_q     <= cps_i * cth_i;
      p_sc_q     <= sps_i * cph_i;
      p_cc_q     <= cps_i * cph_i;
      p_cs_q     <= cps_i * sph_i;
      p_ss_q     <= sps_i * sph_i;
      p_ct2_q    <= sps_i * cth_i;
      p_st_q     <= cps_i * sth_i;
      p_cthsph_q <= cth_i * sph_i;
      p_cthcph_q <= cth_i * cph_i;
      sph_q <= sph_i; cph_q <= cph_i; sth_q <= sth_i;
      op1_q <= op_i;
      t1_q <= 48'(p_st_q) * 48'(sph_q);
      t2_q <= 48'(p_st_q) * 48'(cph_q);
      u1_q <= 48'(p_sc_q) <<< 14;
      u2_q <= 48'(p_ss_q) <<< 14;
      u4_q <= 48'(p_cc_q) <<< 14;
      u5_q <= 48'(p_cs_q) <<< 14;
      e0_q <= rnd2(p_ct_q);
      e3_q <= rnd2(p_ct2_q);
      e6_q <= sat_q14(-48'(sth_q));
      e7_q <= rnd2(p_cthsph_q);
      e8_q <= rnd2(p_cthcph_q);
      op2_q <= op1_q;
    end
  end

  // sps*sth*sph and sps*sth*cph need sps*sth; it is carried in a second
  // product register formed next to the stage one products.
  logic signed [31:0] p_sst_q;
  logic signed [47:0] t4b_q, t5b_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_sst_q <= sps_i * sth_i;
      t4b_q   <= 48'(p_sst_q) * 48'(sph_q);
      t5b_q   <= 48'(p_sst_q) * 48'(cph_q);
    end
  end

  always_comb begin
    m[0] = e0_q;
    m[1] = rnd3(t1_q - u1_q);
    m[2] = rnd3(t2_q + u2_q);
    m[3] = e3_q;
    m[4] = rnd3(t4b_q + u4_q);
    m[5] = rnd3(t5b_q - u5_q);
    m[6] = e6_q;
    m[7] = e7_q;
    m[8] = e8_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (op2_q) begin
        mat_q <= '{m[0], m[3], m[6], m[1], m[4], m[7], m[2], m[5], m[8]};
      end else begin
        mat_q <= '{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
      end
    end
  end

  assign mat_o = mat_q;

endmodule

[rtl/euler_to_direction_cosine_matrix.sv]
// Data path: range reduction, CORDIC cells (at most 24), rounding, matrix.
// Throughput: one beat per cycle; the whole pipeline advances together when
// the output register is empty or being taken.
// Reset: rst_ni clears only the valid bits of the pipeline; payload needs none.
// ----------------------------------------------------------------------------
// euler_to_direction_cosine_matrix
// ZYX Euler angles to rotation matrix (or its transpose when op is set) via a row of CORDIC cells.
// ----------------------------------------------------------------------------
`include "euler_to_direction_cosine_matrix_assert.svh"
module euler_to_direction_cosine_matrix import e2d_pkg::*; #(
  parameter int ANGLE_BITS    = AngleBitsDef,
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  e2d_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output e2d_out_t out_data_o
);

  // Stages actually run, and total pipeline depth: one range-reduction
  // register, the cells, one quadrant/rounding register, three matrix stages.
  localparam int NStage = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
  localparam int Depth  = NStage + 5;
  localparam int KeepB  = (ANGLE_BITS > 32) ? 32 : ANGLE_BITS;
  localparam logic [31:0] PhaseMask = ~(32'hFFFF_FFFF >> KeepB);

  // The pipeline moves as one: a bubble-free stall of every stage is simple
  // and keeps the rate at one beat per cycle whenever the sink takes data.
  logic             adv;
  logic [Depth-1:0] vld_q;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end
  assign out_valid_o = vld_q[Depth-1];

  // Range reduction: each angle becomes a quadrant and a residual phase.
  e2d_rot_t   rot_d [3];
  logic [15:0] ang [3];
  assign ang[0] = in_data_i.roll;
  assign ang[1] = in_data_i.pitch;
  assign ang[2] = in_data_i.yaw;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [31:0] p;
      p = (({ang[a], 16'h0000}) & PhaseMask) + 32'h2000_0000;
      rot_d[a].q = p[31:30];
      rot_d[a].x = CordicGain;
      rot_d[a].y = '0;
      rot_d[a].z = CordW'($signed({2'b00, p[29:0]})) - CordW'(32'sh2000_0000);
    end
  end

  e2d_rot_t    chain_rot  [NStage+1][3];
  logic [16:0] chain_side [NStage+1];
  e2d_rot_t    red_q [3];
  logic        op0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q <= rot_d;
      op0_q <= in_data_i.op;
    end
  end
  assign chain_rot[0]  = red_q;
  assign chain_side[0] = {16'h0000, op0_q};

  for (genvar s = 0; s < NStage; s++) begin : g_cell
    e2d_cordic_cell #(.Stage(s)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rot_i  (chain_rot[s]),
      .side_i (chain_side[s]),
      .rot_o  (chain_rot[s+1]),
      .side_o (chain_side[s+1])
    );
  end

  // Quadrant fold and rounding to Q2.14.
  logic signed [15:0] sn_d [3], cs_d [3], sn_q [3], cs_q [3];
  logic               op3_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [CordW-1:0] c, sv;
      case (chain_rot[NStage][a].q)
        2'd0: begin c = chain_rot[NStage][a].x;  sv = chain_rot[NStage][a].y; end
        2'd1: begin c = -chain_rot[NStage][a].y; sv = chain_rot[NStage][a].x; end
        2'd2: begin c = -chain_rot[NStage][a].x; sv = -chain_rot[NStage][a].y; end
        default: begin c = chain_rot[NStage][a].y; sv = -chain_rot[NStage][a].x; end
      endcase
      cs_d[a] = sat_q14(48'((c + 34'sd32768) >>> 16));
      sn_d[a] = sat_q14(48'((sv + 34'sd32768) >>> 16));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sn_q  <= sn_d;
      cs_q  <= cs_d;
      op3_q <= chain_side[NStage][0];
    end
  end

  e2d_matrix u_matrix (
    .clk_i (clk_i),
    .en_i  (adv),
    .op_i  (op3_q),
    .sph_i (sn_q[0]), .cph_i (cs_q[0]),
    .sth_i (sn_q[1]), .cth_i (cs_q[1]),
    .sps_i (sn_q[2]), .cps_i (cs_q[2]),
    .mat_o (out_data_o)
  );

  // A stalled result must be held by the whole pipeline.
  `E2D_ASSERT(a_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o, "lost result")
  `E2D_ASSERT(a_stall, clk_i, rst_ni, in_stall_o == (out_valid_o && out_stall_i), "bad stall")
  `E2D_ASSERT_RANGE(a_m00, clk_i, rst_ni, out_valid_o, out_data_o.m00, 16'sd16384, "m00 out of range")

endmodule
